// ===== rtl/assert_macros.svh =====
// Assertion macros used by the commitment update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define CUF_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define CUF_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// cond must never be seen
`define CUF_ASSERT_NEVER(name, clk_s, rst_s, cond) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

// ===== rtl/cuf_pkg.sv =====
// Types, codes and constants of the commitment update block.
package cuf_pkg;

	localparam int ACT_W     = 2;
	localparam int OPT_W     = 2;
	localparam int QUAL_W    = 7;
	localparam int DRAW_W    = 14;
	localparam int PERIOD_W  = 16;
	localparam int RATE_W    = 16;
	localparam int SIGMA_W   = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DEN_W     = 27;
	localparam int K_W       = 4;

	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_AGENT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BEACON = 2'd2;

	localparam logic [OPT_W-1:0] OPT_NONE = 2'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_MILLI   = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd400;
	localparam logic [RATE_W-1:0]   RATE_RST   = 16'd9920;
	localparam logic [SIGMA_W-1:0]  SIGMA_RST  = 10'd300;

	// divisors of the three threshold formulas
	localparam logic [DEN_W-1:0] DEN_QUAL = 27'd1000000;
	localparam logic [DEN_W-1:0] DEN_ABAN = 27'd100000;
	localparam logic [DEN_W-1:0] DEN_INH  = 27'd100000000;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [OPT_W-1:0]  msg_option;
		logic [QUAL_W-1:0] msg_quality;
		logic [DRAW_W-1:0] random_draw;
	} cuf_item_t;

	typedef struct packed {
		logic [OPT_W-1:0]  commitment;
		logic [QUAL_W-1:0] own_quality;
		logic              changed;
		logic              update_fired;
	} cuf_result_t;

	// floor(q / 10) as (q * 205) >> 11, exact over the 7-bit range
	function automatic logic [K_W-1:0] quality_tenths(input logic [QUAL_W-1:0] q);
		logic [QUAL_W+7:0] p;
		p = (QUAL_W+8)'(q) * (QUAL_W+8)'(205);
		return p[QUAL_W+7:11];
	endfunction

endpackage

// ===== rtl/cuf_sermul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module cuf_sermul #(
	parameter int AW = 40,
	parameter int BW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [AW-1:0] p
);

	localparam int CW = $clog2(BW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [AW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// ===== rtl/cuf_serdiv.sv =====
// Restoring divider, one quotient bit per cycle.
module cuf_serdiv #(
	parameter int NW = 40,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// numerator shifts out at the top, quotient bits shift in at the bottom
	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== rtl/commitment_update_fsm.sv =====
// Commitment update block: tick counter, message latches, serial threshold engine.
// Messages, ignored actions and ticks that do not fire load the result directly,
// or through EMIT while the output is held. A firing tick runs RSP, then at most
// two thresholds on the shift-add multiplier and restoring divider, abandonment
// on the divider only; no item is taken meanwhile. NW = 26 + clog2(PROB_RANGE+1).
// Reset clears all agent state and loads the default configuration.
`include "assert_macros.svh"

module commitment_update_fsm #(
	parameter int PROB_RANGE = 10000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  cuf_pkg::cuf_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output cuf_pkg::cuf_result_t                result,
	input  logic                                cfg_we,
	input  logic [cuf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cuf_pkg::CFG_W-1:0]           cfg_wdata
);

	localparam int PW    = $clog2(PROB_RANGE + 1);
	localparam int RSP_W = cuf_pkg::RATE_W + PW;
	localparam int NW    = RSP_W + cuf_pkg::SIGMA_W;
	localparam int TW    = NW + 1;
	localparam int DW    = cuf_pkg::DEN_W;
	localparam int QW    = cuf_pkg::QUAL_W;
	localparam int OW    = cuf_pkg::OPT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RSP  = 3'd1;
	localparam logic [2:0] ST_JOB  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	// thresholds: discovery, recruitment, abandonment, inhibition
	localparam logic [1:0] JOB_D = 2'd0;
	localparam logic [1:0] JOB_R = 2'd1;
	localparam logic [1:0] JOB_A = 2'd2;
	localparam logic [1:0] JOB_I = 2'd3;

	logic [cuf_pkg::PERIOD_W-1:0] update_period_q;
	logic [cuf_pkg::RATE_W-1:0]   rate_scale_q;
	logic [cuf_pkg::SIGMA_W-1:0]  sigma_milli_q;

	logic [OW-1:0]                commit_state_q;
	logic [QW-1:0]                commit_quality_q;
	logic [OW-1:0]                agent_option_q;
	logic [QW-1:0]                agent_quality_q;
	logic                         agent_seen_q;
	logic [OW-1:0]                beacon_option_q;
	logic [QW-1:0]                beacon_quality_q;
	logic                         beacon_seen_q;
	logic [cuf_pkg::PERIOD_W-1:0] elapsed_q;

	logic [2:0]                   state_q;
	logic [1:0]                   job_q;
	logic                         chg_q;
	logic                         fired_q;
	logic                         result_valid_q;
	cuf_pkg::cuf_result_t         result_q;
	logic [RSP_W-1:0]             rsp_q;
	logic [TW-1:0]                thr1_q;
	logic [cuf_pkg::DRAW_W-1:0]   draw_q;

	logic                         acc;
	logic                         fire;
	logic                         out_free;
	logic                         load_now;
	logic                         emit_now;
	logic [cuf_pkg::PERIOD_W-1:0] elapsed_inc;
	logic [cuf_pkg::K_W-1:0]      k;
	logic                         agent_live;
	logic                         inh_live;
	logic                         job_skip;
	logic                         step_done;

	logic                         mul_start;
	logic [NW-1:0]                mul_a;
	logic [cuf_pkg::RATE_W-1:0]   mul_b;
	logic                         mul_done;
	logic [NW-1:0]                mul_p;
	logic                         div_start;
	logic [NW-1:0]                div_num;
	logic [DW-1:0]                div_den;
	logic                         div_done;
	logic [NW-1:0]                div_quot;

	logic [TW-1:0]                thr_new;
	logic [TW:0]                  thr_sum;
	logic [TW:0]                  draw_ext;
	logic                         le_first;
	logic                         le_new;
	logic                         le_sum;

	assign item_ready   = state_q == ST_IDLE;
	assign acc          = item_valid && item_ready;
	assign elapsed_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign fire         = (item.action == cuf_pkg::ACT_TICK) && (elapsed_inc > update_period_q);
	assign out_free     = !result_valid_q || result_ready;
	assign load_now     = acc && !fire && out_free;
	assign emit_now     = (state_q == ST_EMIT) && out_free;

	assign k          = cuf_pkg::quality_tenths(commit_quality_q);
	assign agent_live = agent_seen_q && (agent_option_q != cuf_pkg::OPT_NONE);
	assign inh_live   = agent_live && (agent_option_q != commit_state_q);

	always_comb begin
		unique case (job_q)
			JOB_D:   job_skip = !beacon_seen_q;
			JOB_R:   job_skip = !agent_live;
			JOB_A:   job_skip = k == '0;
			JOB_I:   job_skip = !inh_live;
			default: job_skip = 1'b1;
		endcase
	end

	assign step_done = ((state_q == ST_JOB) && job_skip) || ((state_q == ST_DIV) && div_done);

	// a skipped threshold counts as 1
	assign thr_new  = (state_q == ST_DIV) ? TW'(div_quot) + TW'(1) : TW'(1);
	assign thr_sum  = (TW+1)'(thr1_q) + (TW+1)'(thr_new);
	assign draw_ext = (TW+1)'(draw_q);
	assign le_first = draw_ext <= (TW+1)'(thr1_q);
	assign le_new   = draw_ext <= (TW+1)'(thr_new);
	assign le_sum   = draw_ext <= thr_sum;

	always_comb begin
		mul_start = (acc && fire) ||
			((state_q == ST_JOB) && !job_skip && (job_q != JOB_A));
		mul_a     = (state_q == ST_IDLE) ? NW'(PROB_RANGE) : NW'(rsp_q);
		case (job_q)
			JOB_D:   mul_b = cuf_pkg::RATE_W'(beacon_quality_q);
			JOB_R:   mul_b = cuf_pkg::RATE_W'(agent_quality_q);
			JOB_I:   mul_b = cuf_pkg::RATE_W'(sigma_milli_q);
			default: mul_b = '0;
		endcase
		if (state_q == ST_IDLE) begin
			mul_b = rate_scale_q;
		end
		div_start = ((state_q == ST_JOB) && !job_skip && (job_q == JOB_A)) ||
			((state_q == ST_MUL) && mul_done);
		div_num   = (state_q == ST_JOB) ? NW'(rsp_q) : mul_p;
		case (job_q)
			JOB_A:   div_den = DW'(cuf_pkg::DEN_ABAN * DW'(k));
			JOB_I:   div_den = cuf_pkg::DEN_INH;
			default: div_den = cuf_pkg::DEN_QUAL;
		endcase
	end

	cuf_sermul #(
		.AW (NW),
		.BW (cuf_pkg::RATE_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	cuf_serdiv #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_period_q  <= cuf_pkg::PERIOD_RST;
			rate_scale_q     <= cuf_pkg::RATE_RST;
			sigma_milli_q    <= cuf_pkg::SIGMA_RST;
			commit_state_q   <= '0;
			commit_quality_q <= '0;
			agent_option_q   <= '0;
			agent_quality_q  <= '0;
			agent_seen_q     <= 1'b0;
			beacon_option_q  <= '0;
			beacon_quality_q <= '0;
			beacon_seen_q    <= 1'b0;
			elapsed_q        <= '0;
			state_q          <= ST_IDLE;
			job_q            <= JOB_D;
			chg_q            <= 1'b0;
			fired_q          <= 1'b0;
			result_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cuf_pkg::CFG_UPDATE_PERIOD: update_period_q <= cfg_wdata;
					cuf_pkg::CFG_RATE_SCALE:    rate_scale_q    <= cfg_wdata;
					cuf_pkg::CFG_SIGMA_MILLI:   sigma_milli_q   <= cfg_wdata[cuf_pkg::SIGMA_W-1:0];
					default: ;
				endcase
			end

			if (load_now || emit_now) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (item.action)
							cuf_pkg::ACT_TICK: begin
								elapsed_q <= fire ? '0 : elapsed_inc;
							end
							cuf_pkg::ACT_AGENT: begin
								agent_option_q  <= item.msg_option;
								agent_quality_q <= item.msg_quality;
								agent_seen_q    <= 1'b1;
							end
							cuf_pkg::ACT_BEACON: begin
								beacon_option_q  <= item.msg_option;
								beacon_quality_q <= item.msg_quality;
								beacon_seen_q    <= 1'b1;
							end
							default: ;
						endcase
						chg_q   <= 1'b0;
						fired_q <= fire;
						if (fire) begin
							state_q <= ST_RSP;
						end else if (!out_free) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RSP: begin
					if (mul_done) begin
						job_q   <= (commit_state_q == cuf_pkg::OPT_NONE) ? JOB_D : JOB_A;
						state_q <= ST_JOB;
					end
				end
				ST_JOB: begin
					if (!job_skip) begin
						state_q <= (job_q == JOB_A) ? ST_DIV : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: ;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (step_done) begin
				unique case (job_q)
					JOB_D: begin
						job_q   <= JOB_R;
						state_q <= ST_JOB;
					end
					JOB_R: begin
						agent_seen_q  <= 1'b0;
						beacon_seen_q <= 1'b0;
						state_q       <= ST_EMIT;
						if (le_first) begin
							commit_state_q   <= beacon_option_q;
							commit_quality_q <= beacon_quality_q;
							chg_q            <= 1'b1;
						end else if (le_sum) begin
							commit_state_q   <= agent_option_q;
							commit_quality_q <= agent_quality_q;
							chg_q            <= 1'b1;
						end
					end
					JOB_A: begin
						// own quality below ten: always abandon
						if ((k == '0) || le_new) begin
							commit_state_q   <= cuf_pkg::OPT_NONE;
							commit_quality_q <= '0;
							chg_q            <= 1'b1;
							agent_seen_q     <= 1'b0;
							beacon_seen_q    <= 1'b0;
							state_q          <= ST_EMIT;
						end else begin
							job_q   <= JOB_I;
							state_q <= ST_JOB;
						end
					end
					JOB_I: begin
						agent_seen_q  <= 1'b0;
						beacon_seen_q <= 1'b0;
						state_q       <= ST_EMIT;
						if (le_sum) begin
							commit_state_q   <= cuf_pkg::OPT_NONE;
							commit_quality_q <= '0;
							chg_q            <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			draw_q <= item.random_draw;
		end
		if ((state_q == ST_RSP) && mul_done) begin
			rsp_q <= mul_p[RSP_W-1:0];
		end
		if (step_done && ((job_q == JOB_D) || (job_q == JOB_A))) begin
			thr1_q <= thr_new;
		end
		if (load_now || emit_now) begin
			result_q.commitment   <= commit_state_q;
			result_q.own_quality  <= commit_quality_q;
			result_q.changed      <= emit_now && chg_q;
			result_q.update_fired <= emit_now && fired_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`CUF_ASSERT_NEVER(a_units_overlap, clk, arst_n, mul_done && div_done)
	`CUF_ASSERT_NEXT(a_fire_restarts, clk, arst_n, acc && fire, (elapsed_q == '0) && (state_q == ST_RSP))
	`CUF_ASSERT_IMPLY(a_change_needs_fire, clk, arst_n, result_valid_q, !result_q.changed || result_q.update_fired)

endmodule
